/* design/olte_pkg.sv */
package olte_pkg;

   localparam int REQ_W    = 3;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [COUNT_W-1:0] count_out_type;

   typedef enum logic [REQ_W-1:0] {
      RQ_APPEND,
      RQ_DELETE,
      RQ_LOOKUP,
      RQ_REWIND,
      RQ_NEXT
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_NOT_FOUND,
      ST_FULL,
      ST_NO_NEXT
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_CMP,
      FSM_UPD
   } fsm_type;

   // broadcast to every cell in the update cycle
   typedef struct packed {
      logic append_en;
      logic delete_en;
   } cell_ctl_type;

   // rippled from the head cell towards the tail
   typedef struct packed {
      logic seen;
      logic before_cur;
   } chain_type;

endpackage

/* design/olte_if.sv */
interface olte_req_if;
   logic                        valid;
   logic                        ready;
   logic [olte_pkg::REQ_W-1:0]  req_type;
   olte_pkg::word_type          item_value;

   modport source (output valid, req_type, item_value, input ready);
   modport sink   (input valid, req_type, item_value, output ready);
endinterface

interface olte_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [olte_pkg::STATUS_W-1:0]  status;
   logic                           found;
   olte_pkg::word_type             read_value;
   logic                           has_more;
   olte_pkg::count_out_type        entry_count;
   logic                           is_empty;

   modport source (output valid, status, found, read_value, has_more, entry_count, is_empty,
                   input ready);
   modport sink   (input valid, status, found, read_value, has_more, entry_count, is_empty,
                   output ready);
endinterface

/* design/olte_cell.sv */
module olte_cell #(
   parameter int ItemW   = 32,
   parameter int CntW    = 5,
   parameter int CellIdx = 0
) (
   input  logic                  clock,
   input  logic [ItemW-1:0]      key,
   input  logic [CntW-1:0]       count,
   input  logic [CntW-1:0]       cursor,
   input  olte_pkg::cell_ctl_type ctl,
   input  logic [ItemW-1:0]      next_data,
   input  olte_pkg::chain_type   chain_in,
   output olte_pkg::chain_type   chain_out,
   input  logic [ItemW-1:0]      rd_in,
   output logic [ItemW-1:0]      rd_out,
   output logic [ItemW-1:0]      data
);

   localparam logic [CntW-1:0] MyIdx = CntW'(CellIdx);

   logic [ItemW-1:0] data_ff, data_in;
   logic             match_ff, below_ff, at_cur_ff;

   always_ff @(posedge clock) begin
      match_ff  <= (data_ff == key) && (MyIdx < count);
      below_ff  <= (MyIdx < cursor);
      at_cur_ff <= (MyIdx == cursor);
      data_ff   <= data_in;
   end

   assign chain_out.seen       = chain_in.seen | match_ff;
   assign chain_out.before_cur = chain_in.before_cur | (match_ff & below_ff);
   assign rd_out               = rd_in | (at_cur_ff ? data_ff : '0);
   assign data                 = data_ff;

   // delete: every cell from the first match onwards takes its upper neighbour
   always_comb begin
      data_in = data_ff;
      if (ctl.append_en && (MyIdx == count)) begin
         data_in = key;
      end else if (ctl.delete_en && chain_out.seen) begin
         data_in = next_data;
      end
   end

endmodule

/* design/ordered_list_table_engine_unit.sv */
// channel | dir | words
// req_chan | in  | req_type, item_value
// rsp_chan | out | status, found, read_value, has_more, entry_count, is_empty
//
// Each word passes a compare step in every cell, then shift/capture and result.
// A new request is taken while the result is loaded, so requests follow back to back.
// The ripple through the cell row (first match, cursor read) sets the update-cycle path.
// A result waiting on rsp_chan stalls the update cycle until it is taken.
// Synchronous reset empties the list and clears the cursor; cell data is not cleared.
module ordered_list_table_engine_unit #(
   parameter int CAPACITY   = 16,
   parameter int ITEM_WIDTH = 32
) (
   input logic         clock,
   input logic         reset,
   olte_req_if.sink    req_chan,
   olte_rsp_if.source  rsp_chan
);

   localparam int StoreW = (ITEM_WIDTH > olte_pkg::WORD_W) ? olte_pkg::WORD_W : ITEM_WIDTH;
   localparam int CntW   = $clog2(CAPACITY + 1);
   localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

   olte_pkg::fsm_type           state_ff, state_in;
   logic [olte_pkg::REQ_W-1:0]  op_ff;
   logic [StoreW-1:0]           key_ff;
   logic [CntW-1:0]             count_ff, count_in;
   logic [CntW-1:0]             cursor_ff, cursor_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   olte_pkg::status_type        status_ff, status_in;
   logic                        found_ff, found_in;
   logic [StoreW-1:0]           rd_ff, rd_in;
   logic                        more_ff;
   logic [CntW-1:0]             cnt_out_ff;

   logic                        ready, accept, load_rsp, out_free, full;
   olte_pkg::cell_ctl_type      ctl;
   olte_pkg::chain_type         chain [CAPACITY+1];
   logic [StoreW-1:0]           rd_chain [CAPACITY+1];
   logic [StoreW-1:0]           cell_data [CAPACITY+1];

   assign chain[0]            = '0;
   assign rd_chain[0]         = '0;
   assign cell_data[CAPACITY] = '0;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      olte_cell #(
         .ItemW   (StoreW),
         .CntW    (CntW),
         .CellIdx (g)
      ) u_cell (
         .clock     (clock),
         .key       (key_ff),
         .count     (count_ff),
         .cursor    (cursor_ff),
         .ctl       (ctl),
         .next_data (cell_data[g+1]),
         .chain_in  (chain[g]),
         .chain_out (chain[g+1]),
         .rd_in     (rd_chain[g]),
         .rd_out    (rd_chain[g+1]),
         .data      (cell_data[g])
      );
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign accept   = req_chan.valid && ready;
   assign full     = (count_ff >= CapCnt);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olte_pkg::FSM_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_chan.req_type;
         key_ff <= StoreW'(req_chan.item_value);
      end
      if (load_rsp) begin
         status_ff  <= status_in;
         found_ff   <= found_in;
         rd_ff      <= rd_in;
         more_ff    <= (cursor_in < count_in);
         cnt_out_ff <= count_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ready    = 1'b0;
      load_rsp = 1'b0;
      case (state_ff)
         olte_pkg::FSM_IDLE: begin
            ready = 1'b1;
            if (req_chan.valid) begin
               state_in = olte_pkg::FSM_CMP;
            end
         end
         olte_pkg::FSM_CMP: begin
            state_in = olte_pkg::FSM_UPD;
         end
         olte_pkg::FSM_UPD: begin
            if (out_free) begin
               load_rsp = 1'b1;
               ready    = 1'b1;
               state_in = req_chan.valid ? olte_pkg::FSM_CMP : olte_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = olte_pkg::FSM_IDLE;
         end
      endcase
      if (reset) begin
         ready = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_comb begin
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      status_in     = olte_pkg::ST_OK;
      found_in      = 1'b0;
      rd_in         = '0;
      ctl.append_en = 1'b0;
      ctl.delete_en = 1'b0;
      if (load_rsp) begin
         case (op_ff)
            olte_pkg::RQ_APPEND: begin
               if (full) begin
                  status_in = olte_pkg::ST_FULL;
               end else begin
                  ctl.append_en = 1'b1;
                  count_in      = CntW'(count_ff + 1'b1);
                  if (cursor_ff >= count_ff) begin
                     cursor_in = CntW'(count_ff + 1'b1);
                  end
               end
            end
            olte_pkg::RQ_DELETE: begin
               if (!chain[CAPACITY].seen) begin
                  status_in = olte_pkg::ST_NOT_FOUND;
               end else begin
                  found_in      = 1'b1;
                  ctl.delete_en = 1'b1;
                  count_in      = CntW'(count_ff - 1'b1);
                  if (chain[CAPACITY].before_cur) begin
                     cursor_in = CntW'(cursor_ff - 1'b1);
                  end else if (cursor_ff > CntW'(count_ff - 1'b1)) begin
                     cursor_in = CntW'(count_ff - 1'b1);
                  end
               end
            end
            olte_pkg::RQ_LOOKUP: begin
               found_in = chain[CAPACITY].seen;
               if (!chain[CAPACITY].seen) begin
                  status_in = olte_pkg::ST_NOT_FOUND;
               end
            end
            olte_pkg::RQ_REWIND: begin
               cursor_in = '0;
            end
            olte_pkg::RQ_NEXT: begin
               if (cursor_ff < count_ff) begin
                  rd_in     = rd_chain[CAPACITY];
                  cursor_in = CntW'(cursor_ff + 1'b1);
               end else begin
                  status_in = olte_pkg::ST_NO_NEXT;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign req_chan.ready       = ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.found       = found_ff;
   assign rsp_chan.read_value  = olte_pkg::word_type'(rd_ff);
   assign rsp_chan.has_more    = more_ff;
   assign rsp_chan.entry_count = olte_pkg::count_out_type'(cnt_out_ff);
   assign rsp_chan.is_empty    = (cnt_out_ff == '0);

`ifndef ASSERT_OFF
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CapCnt)
      else $error("stored count above capacity");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= count_ff)
      else $error("cursor beyond stored count");

   a_accept_cmp: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == olte_pkg::FSM_CMP)
      else $error("accepted word did not enter compare");

   a_upd_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == olte_pkg::FSM_UPD && rsp_valid_ff && !rsp_chan.ready)
         |=> state_ff == olte_pkg::FSM_UPD && $stable(count_ff) && $stable(cursor_ff))
      else $error("update went ahead over a waiting result");

   a_delete_found: assert property (@(posedge clock) disable iff (reset)
      ctl.delete_en |-> chain[CAPACITY].seen && count_ff != '0)
      else $error("delete shift without a match");
`endif

endmodule

/* test/ordered_list_table_engine_unit_tb.sv */
`timescale 1ns / 1ps

module ordered_list_table_engine_unit_tb;

   localparam int CAPACITY     = 16;
   localparam int RANDOM_WORDS = 700;
   localparam int STALL_LIMIT  = 5000;

   // request codes the block must ignore
   localparam logic [olte_pkg::REQ_W-1:0] RQ_SPARE_5 = 3'd5;
   localparam logic [olte_pkg::REQ_W-1:0] RQ_SPARE_6 = 3'd6;
   localparam logic [olte_pkg::REQ_W-1:0] RQ_SPARE_7 = 3'd7;

   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_SCAN  = 2;
   localparam int MODE_MIXED = 3;

   typedef struct packed {
      olte_pkg::status_type    status;
      logic                    found;
      olte_pkg::word_type      read_value;
      logic                    has_more;
      olte_pkg::count_out_type entry_count;
      logic                    is_empty;
   } list_result_type;

   typedef struct {
      logic [olte_pkg::REQ_W-1:0] code;
      olte_pkg::word_type         value;
      bit                         typed;
      list_result_type            want;
   } plan_row_type;

   logic clock;
   logic reset;
   logic quiet;

   int unsigned err_count    = 0;
   int unsigned stall_cycles = 0;
   int unsigned sent_words   = 0;
   int unsigned got_words    = 0;
   int unsigned n_by_code[8];
   int unsigned n_by_status[4];

   list_result_type awaited_results[$];

   olte_pkg::word_type shadow_list[CAPACITY];
   int                 shadow_count;
   int                 shadow_cursor;

   olte_req_if req_chan();
   olte_rsp_if rsp_chan();

   ordered_list_table_engine_unit #(
      .CAPACITY   (CAPACITY),
      .ITEM_WIDTH (olte_pkg::WORD_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic list_result_type list_apply(input logic [olte_pkg::REQ_W-1:0] code,
                                                  input olte_pkg::word_type val);
      list_result_type r;
      int pos;
      r = '0;
      r.status = olte_pkg::ST_OK;
      pos = -1;
      case (code)
         olte_pkg::RQ_APPEND: begin
            if (shadow_count >= CAPACITY) begin
               r.status = olte_pkg::ST_FULL;
            end else begin
               shadow_list[shadow_count] = val;
               if (shadow_cursor >= shadow_count) shadow_cursor = shadow_count + 1;
               shadow_count++;
            end
         end
         olte_pkg::RQ_DELETE, olte_pkg::RQ_LOOKUP: begin
            for (int i = shadow_count - 1; i >= 0; i--)
               if (shadow_list[i] == val) pos = i;
            if (pos < 0) begin
               r.status = olte_pkg::ST_NOT_FOUND;
            end else begin
               r.found = 1'b1;
               if (code == olte_pkg::RQ_DELETE) begin
                  for (int i = pos; i < shadow_count - 1; i++)
                     shadow_list[i] = shadow_list[i + 1];
                  shadow_count--;
                  if (pos < shadow_cursor) shadow_cursor--;
                  if (shadow_cursor > shadow_count) shadow_cursor = shadow_count;
               end
            end
         end
         olte_pkg::RQ_REWIND: begin
            shadow_cursor = 0;
         end
         olte_pkg::RQ_NEXT: begin
            if (shadow_cursor < shadow_count) begin
               r.read_value = shadow_list[shadow_cursor];
               shadow_cursor++;
            end else begin
               r.status = olte_pkg::ST_NO_NEXT;
            end
         end
         default: begin
         end
      endcase
      r.has_more    = (shadow_cursor < shadow_count);
      r.entry_count = olte_pkg::COUNT_W'(shadow_count);
      r.is_empty    = (shadow_count == 0);
      return r;
   endfunction

   function automatic olte_pkg::word_type pick_value();
      int unsigned roll;
      roll = $urandom_range(99);
      if (shadow_count > 0 && roll < 40) return shadow_list[$urandom_range(shadow_count - 1)];
      if (roll < 70) return olte_pkg::word_type'($urandom_range(7));
      if (roll < 80) return roll[0] ? '1 : '0;
      return $urandom();
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      err_count++;
   endtask

   task automatic check_field(input string name, input logic [olte_pkg::WORD_W-1:0] got,
                              input logic [olte_pkg::WORD_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("word %0d %s got %0h want %0h", got_words, name, got, want));
   endtask

   task automatic send_word(input logic [olte_pkg::REQ_W-1:0] code,
                            input olte_pkg::word_type val,
                            input bit typed = 1'b0, input list_result_type want = '0);
      list_result_type predicted;
      while (!quiet && $urandom_range(99) < 30) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= code;
      req_chan.item_value <= val;
      do @(posedge clock); while (!req_chan.ready);
      predicted = list_apply(code, val);
      awaited_results.push_back(typed ? want : predicted);
      n_by_code[code]++;
      sent_words++;
   endtask

   task automatic hold_until_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_check
      list_result_type got;
      list_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.status      = olte_pkg::status_type'(rsp_chan.status);
            got.found       = rsp_chan.found;
            got.read_value  = rsp_chan.read_value;
            got.has_more    = rsp_chan.has_more;
            got.entry_count = rsp_chan.entry_count;
            got.is_empty    = rsp_chan.is_empty;
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("word %0d arrived with nothing outstanding", got_words));
            end else begin
               want = awaited_results.pop_front();
               check_field("status", olte_pkg::WORD_W'(got.status),
                           olte_pkg::WORD_W'(want.status));
               check_field("found", olte_pkg::WORD_W'(got.found),
                           olte_pkg::WORD_W'(want.found));
               check_field("read_value", got.read_value, want.read_value);
               check_field("has_more", olte_pkg::WORD_W'(got.has_more),
                           olte_pkg::WORD_W'(want.has_more));
               check_field("entry_count", olte_pkg::WORD_W'(got.entry_count),
                           olte_pkg::WORD_W'(want.entry_count));
               check_field("is_empty", olte_pkg::WORD_W'(got.is_empty),
                           olte_pkg::WORD_W'(want.is_empty));
            end
            n_by_status[got.status]++;
            got_words++;
         end
         rsp_chan.ready <= quiet || ($urandom_range(99) >= 30);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("stalled for %0d cycles with %0d words outstanding",
                  stall_cycles, awaited_results.size());
         $display("ordered_list_table_engine_unit_tb NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      plan_row_type               directed_plan[$];
      int                         mode;
      int                         burst_len;
      int                         roll;
      int                         sent_random;
      logic [olte_pkg::REQ_W-1:0] code;

      req_chan.valid      <= 1'b0;
      req_chan.req_type   <= olte_pkg::RQ_APPEND;
      req_chan.item_value <= '0;
      reset               <= 1'b1;
      quiet               <= 1'b0;
      shadow_count  = 0;
      shadow_cursor = 0;
      sent_random   = 0;

      // want: status, found, read_value, has_more, entry_count, is_empty
      directed_plan = '{
         '{olte_pkg::RQ_NEXT, 32'h0, 1'b1,
           {olte_pkg::ST_NO_NEXT, 1'b0, 32'h0, 1'b0, 5'd0, 1'b1}},
         '{olte_pkg::RQ_DELETE, 32'h0, 1'b1,
           {olte_pkg::ST_NOT_FOUND, 1'b0, 32'h0, 1'b0, 5'd0, 1'b1}},
         '{olte_pkg::RQ_LOOKUP, 32'hFFFF_FFFF, 1'b1,
           {olte_pkg::ST_NOT_FOUND, 1'b0, 32'h0, 1'b0, 5'd0, 1'b1}},
         '{olte_pkg::RQ_REWIND, 32'hFFFF_FFFF, 1'b1,
           {olte_pkg::ST_OK, 1'b0, 32'h0, 1'b0, 5'd0, 1'b1}},
         // cursor past the end stays there across appends
         '{olte_pkg::RQ_APPEND, 32'h0, 1'b1,
           {olte_pkg::ST_OK, 1'b0, 32'h0, 1'b0, 5'd1, 1'b0}},
         '{olte_pkg::RQ_APPEND, 32'hFFFF_FFFF, 1'b1,
           {olte_pkg::ST_OK, 1'b0, 32'h0, 1'b0, 5'd2, 1'b0}},
         '{olte_pkg::RQ_NEXT, 32'hFFFF_FFFF, 1'b1,
           {olte_pkg::ST_NO_NEXT, 1'b0, 32'h0, 1'b0, 5'd2, 1'b0}},
         '{olte_pkg::RQ_REWIND, 32'h0, 1'b1,
           {olte_pkg::ST_OK, 1'b0, 32'h0, 1'b1, 5'd2, 1'b0}},
         '{olte_pkg::RQ_NEXT, 32'h0, 1'b1,
           {olte_pkg::ST_OK, 1'b0, 32'h0, 1'b1, 5'd2, 1'b0}},
         '{olte_pkg::RQ_NEXT, 32'h0, 1'b1,
           {olte_pkg::ST_OK, 1'b0, 32'hFFFF_FFFF, 1'b0, 5'd2, 1'b0}},
         '{olte_pkg::RQ_LOOKUP, 32'hFFFF_FFFF, 1'b1,
           {olte_pkg::ST_OK, 1'b1, 32'h0, 1'b0, 5'd2, 1'b0}},
         '{olte_pkg::RQ_REWIND, 32'h0, 1'b1,
           {olte_pkg::ST_OK, 1'b0, 32'h0, 1'b1, 5'd2, 1'b0}},
         '{olte_pkg::RQ_APPEND, 32'h5555_5555, 1'b0, '0},
         '{olte_pkg::RQ_APPEND, 32'hAAAA_AAAA, 1'b0, '0},
         '{olte_pkg::RQ_NEXT,   32'h0,         1'b0, '0},
         '{olte_pkg::RQ_NEXT,   32'h0,         1'b0, '0},
         // delete behind the cursor, then at it, then at the tail once read
         '{olte_pkg::RQ_DELETE, 32'h0,         1'b0, '0},
         '{olte_pkg::RQ_DELETE, 32'h5555_5555, 1'b0, '0},
         '{olte_pkg::RQ_NEXT,   32'h0,         1'b0, '0},
         '{olte_pkg::RQ_DELETE, 32'hAAAA_AAAA, 1'b0, '0},
         '{olte_pkg::RQ_LOOKUP, 32'h1234_5678, 1'b0, '0},
         '{olte_pkg::RQ_APPEND, 32'h8000_0001, 1'b0, '0},
         '{RQ_SPARE_5, 32'hFFFF_FFFF, 1'b0, '0},
         '{RQ_SPARE_6, 32'h8000_0001, 1'b0, '0},
         '{RQ_SPARE_7, 32'h0,         1'b0, '0}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i])
         send_word(directed_plan[i].code, directed_plan[i].value,
                   directed_plan[i].typed, directed_plan[i].want);
      hold_until_drained();

      mode = MODE_FILL;
      while (sent_random < RANDOM_WORDS) begin
         burst_len = $urandom_range(8, 40);
         for (int k = 0; k < burst_len && sent_random < RANDOM_WORDS; k++) begin
            roll = $urandom_range(99);
            case (mode)
               MODE_FILL:  code = (roll < 85) ? olte_pkg::RQ_APPEND :
                                  (roll < 93) ? olte_pkg::RQ_LOOKUP : olte_pkg::RQ_NEXT;
               MODE_DRAIN: code = (roll < 60) ? olte_pkg::RQ_DELETE :
                                  (roll < 75) ? olte_pkg::RQ_LOOKUP :
                                  (roll < 85) ? olte_pkg::RQ_NEXT : olte_pkg::RQ_APPEND;
               MODE_SCAN:  code = (k == 0)    ? olte_pkg::RQ_REWIND :
                                  (roll < 70) ? olte_pkg::RQ_NEXT :
                                  (roll < 80) ? olte_pkg::RQ_DELETE :
                                  (roll < 90) ? olte_pkg::RQ_APPEND : olte_pkg::RQ_REWIND;
               default:    code = olte_pkg::REQ_W'($urandom_range(7));
            endcase
            if (sent_random == 300) quiet <= 1'b1;
            if (sent_random == 420) quiet <= 1'b0;
            if (sent_random % 150 == 75) hold_until_drained();
            send_word(code, pick_value());
            sent_random++;
         end
         mode = $urandom_range(MODE_MIXED);
      end

      hold_until_drained();
      repeat (8) @(posedge clock);

      $display("%0d requests: %0d append, %0d delete, %0d lookup, %0d rewind, %0d next, %s",
               sent_words, n_by_code[olte_pkg::RQ_APPEND], n_by_code[olte_pkg::RQ_DELETE],
               n_by_code[olte_pkg::RQ_LOOKUP], n_by_code[olte_pkg::RQ_REWIND],
               n_by_code[olte_pkg::RQ_NEXT],
               $sformatf("%0d spare", n_by_code[RQ_SPARE_5] + n_by_code[RQ_SPARE_6] +
                                      n_by_code[RQ_SPARE_7]));
      $display("%0d results: %0d ok, %0d not found, %0d full, %0d no next; %0d mismatches",
               got_words, n_by_status[olte_pkg::ST_OK], n_by_status[olte_pkg::ST_NOT_FOUND],
               n_by_status[olte_pkg::ST_FULL], n_by_status[olte_pkg::ST_NO_NEXT], err_count);
      if (err_count == 0) begin
         $display("ordered_list_table_engine_unit_tb OK");
      end else begin
         $display("ordered_list_table_engine_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

/* sim.f */
design/olte_pkg.sv
design/olte_if.sv
design/olte_cell.sv
design/ordered_list_table_engine_unit.sv
test/ordered_list_table_engine_unit_tb.sv
